// ----- hw/rtl/sat_trail_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Assignment trail package
// Shared field widths, operation, reason and error codes, and port types.
// ----------------------------------------------------------------------------
package sat_trail_pkg;

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int VAR_W     = 11;
  localparam int KIND_W    = 2;
  localparam int CLS_IN_W  = 16;
  localparam int CLS_OUT_W = 16;
  localparam int LVL_W     = 11;
  localparam int DEPTH_W   = 11;
  localparam int ERR_W     = 2;

  localparam logic [LVL_W-1:0] LEVEL_MAX = 11'h7FF;

  // Default sizes
  localparam int MAX_VARIABLES_DEF = 1024;
  localparam int TRAIL_DEPTH_DEF   = 1024;
  localparam int CLAUSE_BITS_DEF   = 16;

  // Configuration port
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_NUM_VARIABLES = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_DECIDE      = 3'd0,
    OP_PROPAGATE   = 3'd1,
    OP_PROP_CLAUSE = 3'd2,
    OP_ASSUME      = 3'd3,
    OP_POP         = 3'd4,
    OP_TOP         = 3'd5,
    OP_FIND        = 3'd6,
    OP_CLEAR       = 3'd7
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DECISION    = 2'd0,
    KIND_PROPAGATION = 2'd1,
    KIND_ASSUMPTION  = 2'd2,
    KIND_CLAUSE      = 2'd3
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK   = 2'd0,
    ERR_FULL = 2'd1,
    ERR_VAR  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_TOP_RD,
    ST_POP_RD,
    ST_FIND_MAP,
    ST_FIND_RD
  } state_e;

  // Configuration status handed from the register block to the datapath
  typedef struct packed {
    logic             wr;
    logic [VAR_W-1:0] wr_value;
    logic [VAR_W-1:0] num_vars;
  } cfg_t;

  typedef struct packed {
    logic                 found;
    logic [VAR_W-1:0]     entry_variable;
    logic                 entry_assignment;
    logic [KIND_W-1:0]    entry_reason_kind;
    logic [CLS_OUT_W-1:0] entry_clause;
    logic [LVL_W-1:0]     entry_level;
    logic [LVL_W-1:0]     current_level;
    logic [DEPTH_W-1:0]   trail_depth;
    logic [ERR_W-1:0]     error;
  } result_t;

  function automatic kind_e op_kind(op_e op);
    kind_e k;
    k = KIND_DECISION;
    case (op)
      OP_DECIDE:      k = KIND_DECISION;
      OP_PROPAGATE:   k = KIND_PROPAGATION;
      OP_PROP_CLAUSE: k = KIND_CLAUSE;
      OP_ASSUME:      k = KIND_ASSUMPTION;
      default:        k = KIND_DECISION;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/sat_trail_intf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Assignment trail channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sat_trail_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [sat_trail_pkg::OP_W-1:0]       opcode;
  logic [sat_trail_pkg::VAR_W-1:0]      variable;
  logic                                 assignment;
  logic [sat_trail_pkg::CLS_IN_W-1:0]   clause_index;

  modport source (output valid, output opcode, output variable, output assignment,
                  output clause_index, input ready);
  modport sink (input valid, input opcode, input variable, input assignment,
                input clause_index, output ready);
endinterface

interface sat_trail_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic [sat_trail_pkg::VAR_W-1:0]      entry_variable;
  logic                                 entry_assignment;
  logic [sat_trail_pkg::KIND_W-1:0]     entry_reason_kind;
  logic [sat_trail_pkg::CLS_OUT_W-1:0]  entry_clause;
  logic [sat_trail_pkg::LVL_W-1:0]      entry_level;
  logic [sat_trail_pkg::LVL_W-1:0]      current_level;
  logic [sat_trail_pkg::DEPTH_W-1:0]    trail_depth;
  logic [sat_trail_pkg::ERR_W-1:0]      error;

  modport source (output valid, output found, output entry_variable,
                  output entry_assignment, output entry_reason_kind, output entry_clause,
                  output entry_level, output current_level, output trail_depth,
                  output error, input ready);
  modport sink (input valid, input found, input entry_variable, input entry_assignment,
                input entry_reason_kind, input entry_clause, input entry_level,
                input current_level, input trail_depth, input error, output ready);
endinterface

// ----- hw/rtl/sat_assignment_trail.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SAT assignment trail
// Trail stack and variable-to-slot map kept in two synchronous RAMs.
// ----------------------------------------------------------------------------
// Sequencing: a request accepted in IDLE runs in EXEC; the result is registered when the
//   output is free. A pop that leaves entries reads the new top in POP_RD first, a find reads
//   the map in FIND_MAP and, for a live slot, the trail in FIND_RD. No new request is taken
//   until the last result is loaded; each stale entry but the last one adds a TOP_RD read.
// Reset: control clears at once, then a map clearing pass over all MAX_VARIABLES entries
//   runs with ready low; a count write below MAX_VARIABLES reruns it from the new count up.
module sat_assignment_trail #(
  parameter int MAX_VARIABLES = sat_trail_pkg::MAX_VARIABLES_DEF,
  parameter int TRAIL_DEPTH   = sat_trail_pkg::TRAIL_DEPTH_DEF,
  parameter int CLAUSE_BITS   = sat_trail_pkg::CLAUSE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sat_trail_in_if.sink                      item_i,
  sat_trail_out_if.source                   result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sat_trail_pkg::PADDR_W-1:0] paddr,
  input  logic [sat_trail_pkg::PDATA_W-1:0] pwdata,
  output logic [sat_trail_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);

  localparam int VarW   = sat_trail_pkg::VAR_W;
  localparam int LvlW   = sat_trail_pkg::LVL_W;
  localparam int KindW  = sat_trail_pkg::KIND_W;
  localparam int MapAw  = $clog2(MAX_VARIABLES);
  localparam int TrAw   = $clog2(TRAIL_DEPTH);
  localparam int CntW   = $clog2(TRAIL_DEPTH + 1);
  localparam int LimW   = ($clog2(MAX_VARIABLES + 1) > VarW) ?
                          $clog2(MAX_VARIABLES + 1) : VarW;
  localparam int EntryW = VarW + 1 + KindW + CLAUSE_BITS + LvlW;
  localparam int MapW   = 1 + TrAw;
  // entry layout: {variable, assignment, kind, clause, level}
  localparam int ClsLsb  = LvlW;
  localparam int KindLsb = LvlW + CLAUSE_BITS;
  localparam int ValBit  = KindLsb + KindW;
  localparam int VarLsb  = ValBit + 1;

  sat_trail_pkg::cfg_t    cfg;
  sat_trail_pkg::state_e  state_q, state_d;
  sat_trail_pkg::op_e     op_q;
  sat_trail_pkg::result_t out_q, res;

  logic [MapAw-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]    count_q, count_d, cnt_m2;
  logic [LvlW-1:0]    level_q, level_d, new_level;
  logic [EntryW-1:0]  top_q, top_d, new_entry;
  logic [VarW-1:0]    var_q, var_m1;
  logic               val_q;
  logic [sat_trail_pkg::CLS_IN_W-1:0] cls_q;
  logic [CLAUSE_BITS-1:0] cls_st;
  logic               out_valid_q, out_valid_d;
  logic               out_free, load, emit_top, emit_rd, accept;
  logic [LimW-1:0]    lim, wr_lim, max_lim;
  logic               var_ok, top_stale;
  sat_trail_pkg::err_e err;

  logic               tr_we, tr_re;
  logic [TrAw-1:0]    tr_waddr, tr_raddr;
  logic [EntryW-1:0]  tr_wdata, tr_rdata;
  logic               mp_we, mp_re;
  logic [MapAw-1:0]   mp_waddr, mp_raddr;
  logic [MapW-1:0]    mp_wdata, mp_rdata;
  logic               mp_valid;
  logic [TrAw-1:0]    mp_slot;

  sat_trail_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sat_trail_ram #(.WIDTH(EntryW), .DEPTH(TRAIL_DEPTH)) u_trail_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (tr_wdata),
    .re_i    (tr_re),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

  sat_trail_ram #(.WIDTH(MapW), .DEPTH(MAX_VARIABLES)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mp_we),
    .waddr_i (mp_waddr),
    .wdata_i (mp_wdata),
    .re_i    (mp_re),
    .raddr_i (mp_raddr),
    .rdata_o (mp_rdata)
  );

  // Variable limit, clamped to the map size
  assign max_lim = LimW'(MAX_VARIABLES);
  assign lim     = (LimW'(cfg.num_vars) > max_lim) ? max_lim : LimW'(cfg.num_vars);
  assign wr_lim  = (LimW'(cfg.wr_value) > max_lim) ? max_lim : LimW'(cfg.wr_value);

  assign var_ok    = (var_q != '0) && (LimW'(var_q) <= lim);
  assign var_m1    = var_q - VarW'(1);
  assign cnt_m2    = count_q - CntW'(2);
  assign top_stale = LimW'(top_q[VarLsb +: VarW]) > lim;

  assign mp_valid = mp_rdata[MapW-1];
  assign mp_slot  = mp_rdata[TrAw-1:0];

  assign out_free = !out_valid_q || result_o.ready;
  assign item_i.ready = (state_q == sat_trail_pkg::ST_IDLE) && !cfg.wr;
  assign accept = item_i.valid && item_i.ready;

  // New entry for a push
  always_comb begin
    new_level = level_q;
    if ((op_q inside {sat_trail_pkg::OP_DECIDE, sat_trail_pkg::OP_ASSUME}) &&
        (level_q != sat_trail_pkg::LEVEL_MAX)) begin
      new_level = level_q + LvlW'(1);
    end
    cls_st = (op_q == sat_trail_pkg::OP_PROP_CLAUSE) ? CLAUSE_BITS'(cls_q) : '0;
    new_entry = {var_q, val_q, sat_trail_pkg::op_kind(op_q), cls_st, new_level};
  end

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    count_d  = count_q;
    level_d  = level_q;
    top_d    = top_q;
    tr_we    = 1'b0;
    tr_waddr = count_q[TrAw-1:0];
    tr_wdata = new_entry;
    tr_re    = 1'b0;
    tr_raddr = cnt_m2[TrAw-1:0];
    mp_we    = 1'b0;
    mp_waddr = MapAw'(var_m1);
    mp_wdata = {1'b1, count_q[TrAw-1:0]};
    mp_re    = 1'b0;
    mp_raddr = MapAw'(var_m1);
    load     = 1'b0;
    emit_top = 1'b0;
    emit_rd  = 1'b0;
    err      = sat_trail_pkg::ERR_OK;

    case (state_q)
      sat_trail_pkg::ST_SWEEP: begin
        mp_we    = 1'b1;
        mp_waddr = ptr_q;
        mp_wdata = '0;
        if (ptr_q == MapAw'(MAX_VARIABLES - 1)) begin
          state_d = sat_trail_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_q + MapAw'(1);
        end
        // a lower count written mid-pass pulls the pointer back
        if (cfg.wr && (wr_lim < LimW'(ptr_q))) begin
          ptr_d   = MapAw'(wr_lim);
          state_d = sat_trail_pkg::ST_SWEEP;
        end
      end

      sat_trail_pkg::ST_IDLE: begin
        if (cfg.wr) begin
          if (wr_lim < max_lim) begin
            ptr_d   = MapAw'(wr_lim);
            state_d = sat_trail_pkg::ST_SWEEP;
          end
        end else if (item_i.valid) begin
          state_d = sat_trail_pkg::ST_EXEC;
        end
      end

      sat_trail_pkg::ST_EXEC: begin
        case (op_q)
          sat_trail_pkg::OP_DECIDE, sat_trail_pkg::OP_PROPAGATE,
          sat_trail_pkg::OP_PROP_CLAUSE, sat_trail_pkg::OP_ASSUME: begin
            if (out_free) begin
              load    = 1'b1;
              state_d = sat_trail_pkg::ST_IDLE;
              if (!var_ok) begin
                err = sat_trail_pkg::ERR_VAR;
              end else if (count_q == CntW'(TRAIL_DEPTH)) begin
                err = sat_trail_pkg::ERR_FULL;
              end else begin
                tr_we   = 1'b1;
                mp_we   = 1'b1;
                count_d = count_q + CntW'(1);
                level_d = new_level;
                top_d   = new_entry;
              end
            end
          end

          sat_trail_pkg::OP_POP, sat_trail_pkg::OP_TOP: begin
            if (count_q == '0) begin
              if (out_free) begin
                load    = 1'b1;
                state_d = sat_trail_pkg::ST_IDLE;
              end
            end else if (top_stale) begin
              // drop the stale top and fetch the one below
              count_d = count_q - CntW'(1);
              if (count_q > CntW'(1)) begin
                tr_re   = 1'b1;
                state_d = sat_trail_pkg::ST_TOP_RD;
              end
            end else if (op_q == sat_trail_pkg::OP_TOP) begin
              if (out_free) begin
                load     = 1'b1;
                emit_top = 1'b1;
                state_d  = sat_trail_pkg::ST_IDLE;
              end
            end else if (count_q > CntW'(1)) begin
              tr_re   = 1'b1;
              state_d = sat_trail_pkg::ST_POP_RD;
            end else if (out_free) begin
              load     = 1'b1;
              emit_top = 1'b1;
              count_d  = '0;
              level_d  = '0;
              state_d  = sat_trail_pkg::ST_IDLE;
            end
          end

          sat_trail_pkg::OP_FIND: begin
            if (!var_ok) begin
              if (out_free) begin
                load    = 1'b1;
                err     = sat_trail_pkg::ERR_VAR;
                state_d = sat_trail_pkg::ST_IDLE;
              end
            end else begin
              mp_re   = 1'b1;
              state_d = sat_trail_pkg::ST_FIND_MAP;
            end
          end

          sat_trail_pkg::OP_CLEAR: begin
            if (out_free) begin
              load    = 1'b1;
              count_d = '0;
              level_d = '0;
              state_d = sat_trail_pkg::ST_IDLE;
            end
          end

          default: begin
            state_d = sat_trail_pkg::ST_IDLE;
          end
        endcase
      end

      sat_trail_pkg::ST_TOP_RD: begin
        top_d   = tr_rdata;
        state_d = sat_trail_pkg::ST_EXEC;
      end

      sat_trail_pkg::ST_POP_RD: begin
        if (out_free) begin
          load     = 1'b1;
          emit_top = 1'b1;
          count_d  = count_q - CntW'(1);
          level_d  = tr_rdata[LvlW-1:0];
          top_d    = tr_rdata;
          state_d  = sat_trail_pkg::ST_IDLE;
        end
      end

      sat_trail_pkg::ST_FIND_MAP: begin
        if (mp_valid && (CntW'(mp_slot) < count_q)) begin
          tr_re    = 1'b1;
          tr_raddr = mp_slot;
          state_d  = sat_trail_pkg::ST_FIND_RD;
        end else if (out_free) begin
          load    = 1'b1;
          state_d = sat_trail_pkg::ST_IDLE;
        end
      end

      sat_trail_pkg::ST_FIND_RD: begin
        if (out_free) begin
          load = 1'b1;
          // a slot reused by another variable reads as empty
          emit_rd = (tr_rdata[VarLsb +: VarW] == var_q);
          state_d = sat_trail_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sat_trail_pkg::ST_IDLE;
      end
    endcase
  end

  // Result assembly
  always_comb begin
    res = '0;
    if (emit_top) begin
      res.found             = 1'b1;
      res.entry_variable    = top_q[VarLsb +: VarW];
      res.entry_assignment  = top_q[ValBit];
      res.entry_reason_kind = top_q[KindLsb +: KindW];
      res.entry_clause      = sat_trail_pkg::CLS_OUT_W'(top_q[ClsLsb +: CLAUSE_BITS]);
      res.entry_level       = top_q[LvlW-1:0];
    end else if (emit_rd) begin
      res.found             = 1'b1;
      res.entry_variable    = tr_rdata[VarLsb +: VarW];
      res.entry_assignment  = tr_rdata[ValBit];
      res.entry_reason_kind = tr_rdata[KindLsb +: KindW];
      res.entry_clause      = sat_trail_pkg::CLS_OUT_W'(tr_rdata[ClsLsb +: CLAUSE_BITS]);
      res.entry_level       = tr_rdata[LvlW-1:0];
    end
    res.current_level = level_d;
    res.trail_depth   = sat_trail_pkg::DEPTH_W'(count_d);
    res.error         = err;
  end

  assign out_valid_d = load ? 1'b1 : (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sat_trail_pkg::ST_SWEEP;
      ptr_q       <= '0;
      count_q     <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      count_q     <= count_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (accept) begin
      op_q  <= sat_trail_pkg::op_e'(item_i.opcode);
      var_q <= item_i.variable;
      val_q <= item_i.assignment;
      cls_q <= item_i.clause_index;
    end
    if (load) begin
      out_q <= res;
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.found             = out_q.found;
  assign result_o.entry_variable    = out_q.entry_variable;
  assign result_o.entry_assignment  = out_q.entry_assignment;
  assign result_o.entry_reason_kind = out_q.entry_reason_kind;
  assign result_o.entry_clause      = out_q.entry_clause;
  assign result_o.entry_level       = out_q.entry_level;
  assign result_o.current_level     = out_q.current_level;
  assign result_o.trail_depth       = out_q.trail_depth;
  assign result_o.error             = out_q.error;

endmodule

// ----- hw/rtl/sat_trail_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sat_trail_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sat_trail_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Assignment trail configuration registers
// APB-style register block holding the active variable count.
// ----------------------------------------------------------------------------
module sat_trail_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sat_trail_pkg::PADDR_W-1:0]   paddr,
  input  logic [sat_trail_pkg::PDATA_W-1:0]   pwdata,
  output logic [sat_trail_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready,
  output sat_trail_pkg::cfg_t                 cfg_o
);

  logic [sat_trail_pkg::REG_IDX_W-1:0] reg_idx;
  logic                                sel_num;
  logic                                wr_en;
  logic [sat_trail_pkg::VAR_W-1:0]     num_vars_q;
  logic [sat_trail_pkg::VAR_W-1:0]     num_vars_d;

  assign reg_idx = paddr[sat_trail_pkg::PADDR_W-1:2];
  assign sel_num = (reg_idx == sat_trail_pkg::REG_NUM_VARIABLES);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && sel_num;

  assign num_vars_d = wr_en ? pwdata[sat_trail_pkg::VAR_W-1:0] : num_vars_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q <= '0;
    end else begin
      num_vars_q <= num_vars_d;
    end
  end

  assign prdata = sel_num ? sat_trail_pkg::PDATA_W'(num_vars_q) : '0;

  assign cfg_o.wr       = wr_en;
  assign cfg_o.wr_value = pwdata[sat_trail_pkg::VAR_W-1:0];
  assign cfg_o.num_vars = num_vars_q;

endmodule

// ----- hw/rtl/sat_trail_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Assignment trail result checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sat_trail_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  valid_i,
  input logic                                  ready_i,
  input logic                                  found_i,
  input logic [sat_trail_pkg::VAR_W-1:0]       entry_variable_i,
  input logic                                  entry_assignment_i,
  input logic [sat_trail_pkg::KIND_W-1:0]      entry_reason_kind_i,
  input logic [sat_trail_pkg::CLS_OUT_W-1:0]   entry_clause_i,
  input logic [sat_trail_pkg::LVL_W-1:0]       entry_level_i,
  input logic [sat_trail_pkg::LVL_W-1:0]       current_level_i,
  input logic [sat_trail_pkg::DEPTH_W-1:0]     trail_depth_i,
  input logic [sat_trail_pkg::ERR_W-1:0]       error_i
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(found_i) && $stable(entry_variable_i) &&
      $stable(entry_level_i) && $stable(current_level_i) && $stable(trail_depth_i) &&
      $stable(error_i))
    else $error("result changed while stalled");

  // A rejected push or find never returns an entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (error_i != sat_trail_pkg::ERR_OK) |-> !found_i)
    else $error("entry returned with an error");

  // No entry: all entry fields are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !found_i |-> (entry_variable_i == '0) && !entry_assignment_i &&
      (entry_reason_kind_i == '0) && (entry_clause_i == '0) && (entry_level_i == '0))
    else $error("entry fields set without an entry");

  // Returned entries name a real variable and carry a clause only as clause reason
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && found_i |-> (entry_variable_i != '0) &&
      ((entry_reason_kind_i == sat_trail_pkg::KIND_CLAUSE) || (entry_clause_i == '0)))
    else $error("malformed returned entry");

endmodule

bind sat_assignment_trail sat_trail_chk u_sat_trail_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .valid_i             (result_o.valid),
  .ready_i             (result_o.ready),
  .found_i             (result_o.found),
  .entry_variable_i    (result_o.entry_variable),
  .entry_assignment_i  (result_o.entry_assignment),
  .entry_reason_kind_i (result_o.entry_reason_kind),
  .entry_clause_i      (result_o.entry_clause),
  .entry_level_i       (result_o.entry_level),
  .current_level_i     (result_o.current_level),
  .trail_depth_i       (result_o.trail_depth),
  .error_i             (result_o.error)
);

// ----- test/sat_assignment_trail_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Assignment trail testbench
// Drives push, pop, top, find and clear transactions through the request
// channel under random source and sink idling, reprograms the variable count
// over the APB port between phases, and checks every result against a
// shadow copy of the trail, the variable map and the decision level.
// ----------------------------------------------------------------------------
module sat_assignment_trail_test;
  import sat_trail_pkg::*;

  localparam int MAX_VARS     = MAX_VARIABLES_DEF;
  localparam int TRAIL_DEPTH  = TRAIL_DEPTH_DEF;
  localparam int CLAUSE_BITS  = CLAUSE_BITS_DEF;
  localparam int STALL_LIMIT  = 20000;
  localparam int SETTLE_TICKS = 32;
  localparam int SHOW_LIMIT   = 10;
  localparam logic [CLS_IN_W-1:0] CLAUSE_MASK = CLS_IN_W'((64'd1 << CLAUSE_BITS) - 1);

  typedef struct packed {
    logic [VAR_W-1:0]     vid;
    logic                 val;
    kind_e                kind;
    logic [CLS_OUT_W-1:0] cls;
    logic [LVL_W-1:0]     lvl;
  } trail_rec_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sat_trail_in_if  item_if ();
  sat_trail_out_if res_if ();

  sat_assignment_trail u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow state of the block
  trail_rec_t         shadow_trail [TRAIL_DEPTH];
  logic [DEPTH_W-1:0] shadow_slot [MAX_VARS];
  bit                 shadow_slot_ok [MAX_VARS];
  int                 shadow_count;
  int                 shadow_level;
  int                 shadow_nvars;

  result_t pending_results [$];
  int      fail_count;
  int      idle_cycles;
  int      burst_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int active_vars();
    return (shadow_nvars > MAX_VARS) ? MAX_VARS : shadow_nvars;
  endfunction

  function automatic void drop_stale_entries();
    while (shadow_count > 0 && int'(shadow_trail[shadow_count-1].vid) > active_vars())
      shadow_count--;
  endfunction

  function automatic result_t entry_view(trail_rec_t rec);
    result_t r;
    r = '0;
    r.found             = 1'b1;
    r.entry_variable    = rec.vid;
    r.entry_assignment  = rec.val;
    r.entry_reason_kind = rec.kind;
    r.entry_clause      = (rec.kind == KIND_CLAUSE) ? rec.cls : '0;
    r.entry_level       = rec.lvl;
    return r;
  endfunction

  // Apply one request to the shadow state and return the result it should give
  function automatic result_t trail_apply(op_e op, logic [VAR_W-1:0] vid, logic val,
                                          logic [CLS_IN_W-1:0] cls);
    result_t    r;
    trail_rec_t rec;
    kind_e      kind;
    bit         vid_ok;
    int         idx;
    r      = '0;
    vid_ok = (vid >= 1) && (int'(vid) <= active_vars());
    idx    = int'(vid) - 1;
    case (op)
      OP_DECIDE, OP_PROPAGATE, OP_PROP_CLAUSE, OP_ASSUME: begin
        if (!vid_ok) begin
          r.error = ERR_VAR;
        end else if (shadow_count >= TRAIL_DEPTH) begin
          r.error = ERR_FULL;
        end else begin
          case (op)
            OP_DECIDE:      kind = KIND_DECISION;
            OP_PROPAGATE:   kind = KIND_PROPAGATION;
            OP_PROP_CLAUSE: kind = KIND_CLAUSE;
            default:        kind = KIND_ASSUMPTION;
          endcase
          if ((op == OP_DECIDE || op == OP_ASSUME) && shadow_level < int'(LEVEL_MAX))
            shadow_level++;
          rec.vid  = vid;
          rec.val  = val;
          rec.kind = kind;
          rec.cls  = (kind == KIND_CLAUSE) ? CLS_OUT_W'(cls & CLAUSE_MASK) : '0;
          rec.lvl  = LVL_W'(shadow_level);
          shadow_trail[shadow_count] = rec;
          shadow_slot[idx]    = DEPTH_W'(shadow_count);
          shadow_slot_ok[idx] = 1'b1;
          shadow_count++;
        end
      end
      OP_POP: begin
        drop_stale_entries();
        if (shadow_count > 0) begin
          rec = shadow_trail[shadow_count-1];
          shadow_slot_ok[int'(rec.vid) - 1] = 1'b0;
          shadow_count--;
          shadow_level = (shadow_count > 0) ? int'(shadow_trail[shadow_count-1].lvl) : 0;
          r = entry_view(rec);
        end
      end
      OP_TOP: begin
        // Discard stale entries but leave the level alone
        drop_stale_entries();
        if (shadow_count > 0) r = entry_view(shadow_trail[shadow_count-1]);
      end
      OP_FIND: begin
        if (!vid_ok) begin
          r.error = ERR_VAR;
        end else if (shadow_slot_ok[idx] && int'(shadow_slot[idx]) < shadow_count) begin
          r = entry_view(shadow_trail[shadow_slot[idx]]);
        end
      end
      default: begin
        shadow_count = 0;
        shadow_level = 0;
        foreach (shadow_slot_ok[i]) shadow_slot_ok[i] = 1'b0;
      end
    endcase
    r.current_level = LVL_W'(shadow_level);
    r.trail_depth   = DEPTH_W'(shadow_count);
    return r;
  endfunction

  function automatic string fmt_result(result_t r);
    return {$sformatf("found=%0d var=%0d val=%0d kind=%0d clause=%0h ", r.found,
                      r.entry_variable, r.entry_assignment, r.entry_reason_kind,
                      r.entry_clause),
            $sformatf("lvl=%0d cur=%0d depth=%0d err=%0d", r.entry_level,
                      r.current_level, r.trail_depth, r.error)};
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("%t %s", $realtime, msg);
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(op_e op, logic [VAR_W-1:0] vid, logic val,
                           logic [CLS_IN_W-1:0] cls);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) burst_left = 40;
      gap = idle_len();
    end
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid        <= 1'b1;
    item_if.opcode       <= op;
    item_if.variable     <= vid;
    item_if.assignment   <= val;
    item_if.clause_index <= cls;
    do @(posedge clk_i); while (!item_if.ready);
    pending_results.push_back(trail_apply(op, vid, val, cls));
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Program the variable count while idle, then read it back
  task automatic set_var_count(int n);
    wait_drained();
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_NUM_VARIABLES, 2'b00};
    pwdata  <= PDATA_W'(n);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_nvars = n & 'h7FF;
    for (int i = active_vars(); i < MAX_VARS; i++) shadow_slot_ok[i] = 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(shadow_nvars))
      note_failure($sformatf("register readback: expected %0d actual %0d",
                             shadow_nvars, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    // Variable count is zero out of reset: every variable is out of range
    send_item(OP_DECIDE, 11'd1, 1'b1, 16'h0000);
    send_item(OP_FIND, 11'd1, 1'b0, 16'h0000);
    send_item(OP_POP, 11'd0, 1'b0, 16'h0000);
    send_item(OP_TOP, 11'd0, 1'b0, 16'h0000);
    set_var_count(8);
    send_item(OP_DECIDE, 11'd1, 1'b1, 16'h1234);
    send_item(OP_PROPAGATE, 11'd2, 1'b0, 16'hFFFF);
    send_item(OP_PROP_CLAUSE, 11'd3, 1'b1, 16'hFFFF);
    send_item(OP_ASSUME, 11'd4, 1'b0, 16'h5A5A);
    send_item(OP_PROP_CLAUSE, 11'd8, 1'b1, 16'h0000);
    send_item(OP_DECIDE, 11'd0, 1'b1, 16'h0000);
    send_item(OP_ASSUME, 11'd9, 1'b1, 16'h0000);
    send_item(OP_FIND, 11'd3, 1'b0, 16'h0000);
    send_item(OP_FIND, 11'd5, 1'b0, 16'h0000);
    send_item(OP_TOP, 11'd0, 1'b0, 16'h0000);
    // Duplicate push: popping the newer entry empties the slot
    send_item(OP_DECIDE, 11'd2, 1'b1, 16'h0000);
    send_item(OP_FIND, 11'd2, 1'b0, 16'h0000);
    send_item(OP_POP, 11'd0, 1'b0, 16'h0000);
    send_item(OP_FIND, 11'd2, 1'b0, 16'h0000);
    // Lower the count so the top entries go stale
    set_var_count(3);
    send_item(OP_TOP, 11'd0, 1'b0, 16'h0000);
    send_item(OP_POP, 11'd0, 1'b0, 16'h0000);
    send_item(OP_FIND, 11'h7FF, 1'b1, 16'hFFFF);
    send_item(OP_PROPAGATE, 11'd3, 1'b1, 16'h0000);
    send_item(OP_CLEAR, 11'd0, 1'b0, 16'h0000);
    send_item(OP_TOP, 11'd0, 1'b0, 16'h0000);
    send_item(OP_POP, 11'd0, 1'b0, 16'h0000);
    send_item(OP_FIND, 11'd1, 1'b0, 16'h0000);
  endtask

  task automatic test_fill_and_stale();
    set_var_count(MAX_VARS);
    send_item(OP_CLEAR, 11'd0, 1'b0, 16'h0000);
    // Fill with decisions and assumptions on the upper half of the variables
    while (shadow_count < TRAIL_DEPTH) begin
      send_item($urandom_range(0, 1) ? OP_DECIDE : OP_ASSUME,
                VAR_W'($urandom_range(MAX_VARS / 2 + 1, MAX_VARS)),
                1'($urandom_range(0, 1)), CLS_IN_W'($urandom_range(0, 65535)));
    end
    send_item(OP_PROPAGATE, 11'd1, 1'b1, 16'h0000);
    send_item(OP_PROP_CLAUSE, VAR_W'(MAX_VARS), 1'b0, 16'hFFFF);
    send_item(OP_DECIDE, 11'd0, 1'b0, 16'h0000);
    send_item(OP_FIND, VAR_W'($urandom_range(MAX_VARS / 2 + 1, MAX_VARS)), 1'b0, 16'h0000);
    send_item(OP_TOP, 11'd0, 1'b0, 16'h0000);
    // Every entry goes stale; top empties the trail and keeps the level
    set_var_count(MAX_VARS / 2);
    send_item(OP_TOP, 11'd0, 1'b0, 16'h0000);
    send_item(OP_DECIDE, 11'd1, 1'b1, 16'h0000);
    send_item(OP_POP, 11'd0, 1'b0, 16'h0000);
    send_item(OP_TOP, 11'd0, 1'b0, 16'h0000);
    send_item(OP_FIND, 11'd1, 1'b0, 16'h0000);
    send_item(OP_CLEAR, 11'd0, 1'b0, 16'h0000);
  endtask

  task automatic test_random_mix();
    int               counts [8];
    int               lim;
    int               dom;
    int unsigned      r;
    op_e              op;
    logic [VAR_W-1:0] vid;
    counts    = '{1024, 16, 5, 1, 0, 12, 1024, 3};
    counts[5] = $urandom_range(2, 30);
    foreach (counts[p]) begin
      set_var_count(counts[p]);
      repeat (12) begin
        lim = active_vars();
        dom = (lim < 20) ? lim : 20;
        if (lim > 0 && $urandom_range(0, 99) < 85) begin
          vid = VAR_W'($urandom_range(1, dom));
        end else begin
          case ($urandom_range(0, 2))
            0:       vid = '0;
            1:       vid = VAR_W'(lim + 1);
            default: vid = VAR_W'($urandom_range(0, 2047));
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 45)      op = op_e'($urandom_range(0, 3));
        else if (r < 63) op = OP_POP;
        else if (r < 72) op = OP_TOP;
        else if (r < 90) op = OP_FIND;
        else if (r < 93) op = OP_CLEAR;
        else begin
          op  = op_e'($urandom_range(0, 7));
          vid = VAR_W'($urandom_range(0, 2047));
        end
        // Hold off now and then until every result is back
        if ($urandom_range(0, 49) == 0) wait_drained();
        send_item(op, vid, 1'($urandom_range(0, 1)), CLS_IN_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      int unsigned low;
      int unsigned high;
      low  = idle_len();
      high = ($urandom_range(0, 29) == 0) ? 100 : $urandom_range(1, 6);
      if (low > 0) begin
        res_if.ready <= 1'b0;
        repeat (low) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      repeat (high) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t seen;
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen.found             = res_if.found;
      seen.entry_variable    = res_if.entry_variable;
      seen.entry_assignment  = res_if.entry_assignment;
      seen.entry_reason_kind = res_if.entry_reason_kind;
      seen.entry_clause      = res_if.entry_clause;
      seen.entry_level       = res_if.entry_level;
      seen.current_level     = res_if.current_level;
      seen.trail_depth       = res_if.trail_depth;
      seen.error             = res_if.error;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: %s", fmt_result(seen)));
      end else begin
        want = pending_results.pop_front();
        if (seen.found !== want.found || seen.entry_variable !== want.entry_variable ||
            seen.entry_assignment !== want.entry_assignment ||
            seen.entry_reason_kind !== want.entry_reason_kind ||
            seen.entry_clause !== want.entry_clause ||
            seen.entry_level !== want.entry_level ||
            seen.current_level !== want.current_level ||
            seen.trail_depth !== want.trail_depth || seen.error !== want.error)
          note_failure($sformatf("result differs\n  expected %s\n  actual   %s",
                                 fmt_result(want), fmt_result(seen)));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    @(posedge clk_i);
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("sat_assignment_trail: mismatch");
    $finish;
  end

  initial begin
    rst_ni               <= 1'b0;
    item_if.valid        <= 1'b0;
    item_if.opcode       <= OP_DECIDE;
    item_if.variable     <= '0;
    item_if.assignment   <= 1'b0;
    item_if.clause_index <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    fail_count   = 0;
    burst_left   = 0;
    shadow_count = 0;
    shadow_level = 0;
    shadow_nvars = 0;
    foreach (shadow_trail[i]) shadow_trail[i] = '0;
    foreach (shadow_slot[i]) begin
      shadow_slot[i]    = '0;
      shadow_slot_ok[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_stale();
    test_random_mix();
    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (fail_count == 0)
      $display("sat_assignment_trail: match");
    else
      $display("sat_assignment_trail: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sat_trail_pkg.sv
hw/rtl/sat_trail_intf.sv
hw/rtl/sat_trail_ram.sv
hw/rtl/sat_trail_cfg.sv
hw/rtl/sat_assignment_trail.sv
hw/rtl/sat_trail_chk.sv
test/sat_assignment_trail_test.sv
